// File: rtl/assert_macros.svh
// Assertion helpers for RTL files that check their own logic.
// Each macro takes a label, the clock, the active-low reset and two expressions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: rtl/tcfd_pkg.sv
// Constants and types for the text command frame decoder.
// Stand-alone package; used by the top level.
`default_nettype none

package tcfd_pkg;

    localparam int MAX_FRAME   = 32;
    localparam int MAX_LETTERS = 8;

    localparam int KW_IDX_W = $clog2(MAX_LETTERS);

    typedef logic [7:0]                   t_byte;
    typedef logic [MAX_LETTERS-1:0][7:0]  t_kw_buf;

    typedef enum logic [2:0] {
        CMD_NONE   = 3'd0,
        CMD_SERVO  = 3'd1,
        CMD_LCD    = 3'd2,
        CMD_LEDON  = 3'd3,
        CMD_LEDOFF = 3'd4
    } t_cmd;

    localparam t_byte CH_HASH  = 8'h23;
    localparam t_byte CH_SPACE = 8'h20;
    localparam t_byte CH_0     = 8'h30;
    localparam t_byte CH_9     = 8'h39;
    localparam t_byte CH_A     = 8'h61;
    localparam t_byte CH_Z     = 8'h7A;

    // Keywords packed with the first letter in the low byte.
    localparam logic [47:0] KW_SERVO  = 48'h006F76726573;
    localparam logic [47:0] KW_LCD    = 48'h00000064636C;
    localparam logic [47:0] KW_LEDON  = 48'h006E6F64656C;
    localparam logic [47:0] KW_LEDOFF = 48'h66666F64656C;

    localparam logic [3:0] LEN_SERVO  = 4'd5;
    localparam logic [3:0] LEN_LCD    = 4'd3;
    localparam logic [3:0] LEN_LEDON  = 4'd5;
    localparam logic [3:0] LEN_LEDOFF = 4'd6;

endpackage

`default_nettype wire

// File: rtl/text_command_frame_decoder.sv
// A request is accepted into the input register and then processed into the frame
// state and, for a '#', into the result register, where the result waits until taken.
// Throughput: one request per cycle while the result register is empty or being taken;
// the frame state is updated per byte between the input and result registers.
// Reset (synchronous, active low) empties both stages, clears the frame state and
// turns all LEDs off. The keyword letters are not reset.
`default_nettype none
`include "assert_macros.svh"

module text_command_frame_decoder (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_rx_valid,
    output logic                    o_rx_ready,
    input  wire  tcfd_pkg::t_byte   i_rx_byte,
    output logic                    o_valid,
    input  wire                     i_ready,
    output logic [2:0]              o_command,
    output logic [15:0]             o_value,
    output logic [3:0]              o_led_pins,
    output logic                    o_frame_overflow
);
    import tcfd_pkg::*;

    function automatic logic kw_match(input t_kw_buf kbuf, input logic [3:0] klen,
                                      input logic [47:0] word, input logic [3:0] wlen);
        logic ok;
        ok = (klen == wlen);
        for (int i = 0; i < 6; i++) begin
            if (i < int'(wlen) && kbuf[i] != word[8*i +: 8]) begin
                ok = 1'b0;
            end
        end
        return ok;
    endfunction

    // Input stage
    logic       r_in_valid;
    t_byte      r_in_byte;

    // Frame state
    t_kw_buf     r_kw_buf;
    logic [3:0]  r_kw_len;
    logic [5:0]  r_frame_len;
    logic [15:0] r_num;
    logic [3:0]  r_pins;
    logic        r_ovf_seen;
    logic        r_truncated;

    // Result register
    logic        r_out_valid;
    t_cmd        r_cmd;
    logic [15:0] r_value;
    logic        r_ovf;

    logic        adv;
    logic        proc;
    logic        is_hash;
    logic        led_done;

    logic [3:0]  n_kw_len;
    logic [5:0]  n_frame_len;
    logic [15:0] n_num;
    logic [3:0]  n_pins;
    logic        n_ovf_seen;
    logic        n_truncated;
    logic        kw_write;
    t_cmd        n_cmd;
    logic [15:0] n_value;
    logic        n_ovf;
    logic [3:0]  led_mask;
    logic [7:0]  digit;

    assign adv        = !r_out_valid || i_ready;
    assign proc       = r_in_valid && adv;
    assign is_hash    = (r_in_byte == CH_HASH);
    assign o_rx_ready = !r_in_valid || adv;
    assign led_done   = proc && is_hash && (n_cmd == CMD_LEDON || n_cmd == CMD_LEDOFF);

    assign digit    = r_in_byte - CH_0;
    assign led_mask = 4'b0001 << (r_num[1:0] - 2'd1);

    always_comb begin
        n_kw_len    = r_kw_len;
        n_frame_len = r_frame_len;
        n_num       = r_num;
        n_pins      = r_pins;
        n_ovf_seen  = r_ovf_seen;
        n_truncated = r_truncated;
        kw_write    = 1'b0;
        n_cmd       = CMD_NONE;
        n_value     = 16'd0;
        n_ovf       = 1'b0;

        if (r_in_byte == CH_SPACE) begin
            // Spaces do not touch the frame at all.
        end else if (!is_hash) begin
            if (r_frame_len >= 6'(MAX_FRAME)) begin
                n_truncated = 1'b1;
            end else begin
                n_frame_len = r_frame_len + 6'd1;
                if (r_in_byte >= CH_0 && r_in_byte <= CH_9) begin
                    n_num = (r_num << 3) + (r_num << 1) + {8'd0, digit};
                end else if (r_in_byte >= CH_A && r_in_byte <= CH_Z) begin
                    if (r_kw_len >= 4'(MAX_LETTERS)) begin
                        n_ovf_seen = 1'b1;
                    end else begin
                        kw_write = 1'b1;
                        n_kw_len = r_kw_len + 4'd1;
                    end
                end
            end
        end else begin
            if (r_ovf_seen || r_truncated) begin
                n_ovf = 1'b1;
            end else begin
                n_value = r_num;
                if (kw_match(r_kw_buf, r_kw_len, KW_SERVO, LEN_SERVO)) begin
                    n_cmd = CMD_SERVO;
                end else if (kw_match(r_kw_buf, r_kw_len, KW_LCD, LEN_LCD)) begin
                    n_cmd = CMD_LCD;
                end else if (kw_match(r_kw_buf, r_kw_len, KW_LEDON, LEN_LEDON)) begin
                    n_cmd = CMD_LEDON;
                end else if (kw_match(r_kw_buf, r_kw_len, KW_LEDOFF, LEN_LEDOFF)) begin
                    n_cmd = CMD_LEDOFF;
                end
                if (r_num >= 16'd1 && r_num <= 16'd4) begin
                    if (n_cmd == CMD_LEDON) begin
                        n_pins = r_pins | led_mask;
                    end else if (n_cmd == CMD_LEDOFF) begin
                        n_pins = r_pins & ~led_mask;
                    end
                end
            end
            // A closed frame starts the next one empty.
            n_kw_len    = 4'd0;
            n_frame_len = 6'd0;
            n_num       = 16'd0;
            n_ovf_seen  = 1'b0;
            n_truncated = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_kw_len    <= 4'd0;
            r_frame_len <= 6'd0;
            r_num       <= 16'd0;
            r_pins      <= 4'd0;
            r_ovf_seen  <= 1'b0;
            r_truncated <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_rx_ready) begin
                r_in_valid <= i_rx_valid;
            end
            if (proc) begin
                r_kw_len    <= n_kw_len;
                r_frame_len <= n_frame_len;
                r_num       <= n_num;
                r_pins      <= n_pins;
                r_ovf_seen  <= n_ovf_seen;
                r_truncated <= n_truncated;
            end
            if (proc && is_hash) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_rx_ready && i_rx_valid) begin
            r_in_byte <= i_rx_byte;
        end
        if (proc && kw_write) begin
            r_kw_buf[r_kw_len[KW_IDX_W-1:0]] <= r_in_byte;
        end
        if (proc && is_hash) begin
            r_cmd   <= n_cmd;
            r_value <= n_value;
            r_ovf   <= n_ovf;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_command        = r_cmd;
    assign o_value          = r_value;
    assign o_led_pins       = r_pins;
    assign o_frame_overflow = r_ovf;

    `ASSERT_SAME(a_ovf_clear, i_clk, i_rst_n, o_valid && r_ovf, r_cmd == CMD_NONE && r_value == '0)
    `ASSERT_NEXT(a_pins_only_on_led, i_clk, i_rst_n, !led_done, $stable(r_pins))
    `ASSERT_SAME(a_kw_len_bound, i_clk, i_rst_n, 1'b1, r_kw_len <= 4'(MAX_LETTERS))
    `ASSERT_SAME(a_frame_len_bound, i_clk, i_rst_n, 1'b1, r_frame_len <= 6'(MAX_FRAME))

endmodule

`default_nettype wire

// File: test/tb_top.sv
// Self-checking testbench for text_command_frame_decoder: sends byte streams, predicts
// each decoded frame and compares it with the block's output. Depends on tcfd_pkg and
// the decoder RTL only.
`default_nettype none

module tb_top;
    import tcfd_pkg::*;

    typedef t_byte t_byte_q[$];

    typedef struct {
        t_cmd        cmd;
        logic [15:0] value;
        logic [3:0]  pins;
        logic        ovf;
    } t_frame_result;

    localparam int TARGET_RANDOM_BYTES = 1350;
    localparam int TARGET_TOTAL_BYTES  = 1550;
    localparam int RUN_LIMIT_CYCLES    = 500000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_rx_valid;
    logic        o_rx_ready;
    t_byte       i_rx_byte;
    logic        o_valid;
    logic        i_ready;
    logic [2:0]  o_command;
    logic [15:0] o_value;
    logic [3:0]  o_led_pins;
    logic        o_frame_overflow;

    text_command_frame_decoder dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_rx_valid       (i_rx_valid),
        .o_rx_ready       (o_rx_ready),
        .i_rx_byte        (i_rx_byte),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_command        (o_command),
        .o_value          (o_value),
        .o_led_pins       (o_led_pins),
        .o_frame_overflow (o_frame_overflow)
    );

    // Decoder state as the testbench tracks it. Letters shift in at the low byte, so
    // the last n letters read as an n-character string literal.
    logic [8*MAX_LETTERS-1:0] kw_letters;
    int                       kw_count;
    int                       frame_count;
    logic [15:0]              number_acc;
    logic [3:0]               led_state;
    logic                     letters_overflowed;
    logic                     frame_cut;

    t_frame_result expected_frames[$];

    int mismatches   = 0;
    int results_seen = 0;
    int frames_sent  = 0;
    int bytes_sent   = 0;
    bit gaps_on      = 1'b1;
    bit stalls_on    = 1'b1;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #(20 * RUN_LIMIT_CYCLES);
        $display("Timeout with %0d frames still pending.", expected_frames.size());
        $display("*** FAILED ***");
        $finish;
    end

    // Result side: while stalls are enabled, i_ready is held low in random bursts.
    initial begin
        int stall_left;
        stall_left = 0;
        i_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall_left > 0) begin
                stall_left--;
                i_ready <= 1'b0;
            end else if (stalls_on && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(0, 5);
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    function automatic void note_mismatch(string what);
        mismatches++;
        if (mismatches <= 10)
            $display("MISMATCH: %s", what);
    endfunction

    function automatic void clear_frame_state();
        kw_letters = '0;
        kw_count = 0;
        frame_count = 0;
        number_acc = '0;
        letters_overflowed = 1'b0;
        frame_cut = 1'b0;
    endfunction

    // Advances the tracked state by one accepted byte and queues the decoded frame
    // when the byte is the terminator.
    function automatic void decode_byte(t_byte b);
        t_frame_result r;
        if (b == CH_SPACE)
            return;
        if (b != CH_HASH) begin
            if (frame_count >= MAX_FRAME) begin
                frame_cut = 1'b1;
                return;
            end
            frame_count++;
            if (b >= CH_0 && b <= CH_9) begin
                number_acc = number_acc * 10 + (b - CH_0);
            end else if (b >= CH_A && b <= CH_Z) begin
                if (kw_count >= MAX_LETTERS) begin
                    letters_overflowed = 1'b1;
                end else begin
                    kw_letters = {kw_letters[8*MAX_LETTERS-9:0], b};
                    kw_count++;
                end
            end
            return;
        end
        r.cmd = CMD_NONE;
        r.ovf = letters_overflowed || frame_cut;
        r.value = r.ovf ? 16'd0 : number_acc;
        if (!r.ovf) begin
            if (kw_count == 5 && kw_letters[39:0] == "servo")
                r.cmd = CMD_SERVO;
            else if (kw_count == 3 && kw_letters[23:0] == "lcd")
                r.cmd = CMD_LCD;
            else if (kw_count == 5 && kw_letters[39:0] == "ledon")
                r.cmd = CMD_LEDON;
            else if (kw_count == 6 && kw_letters[47:0] == "ledoff")
                r.cmd = CMD_LEDOFF;
            if ((r.cmd == CMD_LEDON || r.cmd == CMD_LEDOFF) &&
                number_acc >= 1 && number_acc <= 4)
                led_state[number_acc - 1] = (r.cmd == CMD_LEDON);
        end
        r.pins = led_state;
        expected_frames.push_back(r);
        clear_frame_state();
    endfunction

    always @(posedge i_clk) begin
        t_frame_result e;
        if (i_rst_n && o_valid && i_ready) begin
            results_seen++;
            if (expected_frames.size() == 0) begin
                note_mismatch($sformatf("result cmd=%0d value=%0d with no frame pending",
                                        o_command, o_value));
            end else begin
                e = expected_frames.pop_front();
                if (o_command !== e.cmd || o_value !== e.value ||
                    o_led_pins !== e.pins || o_frame_overflow !== e.ovf)
                    note_mismatch($sformatf(
                        {"result %0d: expected cmd=%0d value=%0d pins=%h ovf=%0d, ",
                         "got cmd=%0d value=%0d pins=%h ovf=%0d"},
                        results_seen, e.cmd, e.value, e.pins, e.ovf,
                        o_command, o_value, o_led_pins, o_frame_overflow));
            end
        end
    end

    // Presents one byte request and holds it until accepted, with an optional gap first.
    task automatic send_byte(input t_byte b);
        int gap;
        gap = (gaps_on && $urandom_range(0, 4) == 0) ? $urandom_range(1, 6) : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            i_rx_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_rx_valid <= 1'b1;
        i_rx_byte <= b;
        do @(posedge i_clk); while (!o_rx_ready);
        decode_byte(b);
        bytes_sent++;
        if (b == CH_HASH)
            frames_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(t_byte'(s[i]));
    endtask

    // The sender stays idle until every decoded frame has come back.
    task automatic pause_sender();
        @(negedge i_clk);
        i_rx_valid <= 1'b0;
        while (expected_frames.size() != 0)
            @(posedge i_clk);
    endtask

    function automatic void append_text(ref t_byte_q q, input string s);
        for (int i = 0; i < s.len(); i++)
            q.push_back(t_byte'(s[i]));
    endfunction

    task automatic send_random_frame();
        t_byte_q body;
        t_byte_q digits;
        int      kind;
        t_byte   b;
        kind = $urandom_range(0, 19);
        if (kind < 15) begin
            // Keyword, near miss or random letters plus an optional random number, with random spacing.
            case ($urandom_range(0, 7))
                0, 1: append_text(body, "ledon");
                2, 3: append_text(body, "ledoff");
                4: append_text(body, "servo");
                5: append_text(body, "lcd");
                6: append_text(body, "led");
                default: begin
                    repeat ($urandom_range(0, 8))
                        body.push_back(t_byte'(CH_A + $urandom_range(0, 25)));
                end
            endcase
            case ($urandom_range(0, 4))
                0, 1: append_text(digits, $sformatf("%0d", $urandom_range(0, 5)));
                2: append_text(digits, $sformatf("%0d", $urandom_range(0, 65535)));
                3: begin
                    repeat ($urandom_range(6, 14))
                        digits.push_back(t_byte'(CH_0 + $urandom_range(0, 9)));
                end
                default: ;
            endcase
            if ($urandom_range(0, 5) == 0) begin
                foreach (body[i]) digits.push_back(body[i]);
                body = digits;
            end else begin
                foreach (digits[i]) body.push_back(digits[i]);
            end
        end else if (kind < 17) begin
            // Too many letters for the keyword store.
            repeat ($urandom_range(MAX_LETTERS + 1, MAX_LETTERS + 6))
                body.push_back(t_byte'(CH_A + $urandom_range(0, 25)));
            append_text(body, $sformatf("%0d", $urandom_range(0, 9)));
        end else if (kind == 17) begin
            // Long frame, near and past the frame limit.
            repeat ($urandom_range(MAX_FRAME - 2, MAX_FRAME + 8)) begin
                case ($urandom_range(0, 3))
                    0: b = t_byte'(CH_A + $urandom_range(0, 25));
                    1: b = t_byte'(CH_0 + $urandom_range(0, 9));
                    2: b = CH_SPACE;
                    default: begin
                        b = t_byte'($urandom_range(0, 255));
                        if (b == CH_HASH)
                            b = CH_SPACE;
                    end
                endcase
                body.push_back(b);
            end
        end else begin
            // Raw noise; a stray terminator just closes the frame early.
            repeat ($urandom_range(0, 10))
                body.push_back(t_byte'($urandom_range(0, 255)));
        end
        foreach (body[i]) begin
            if ($urandom_range(0, 9) == 0)
                send_byte(CH_SPACE);
            send_byte(body[i]);
        end
        send_byte(CH_HASH);
    endtask

    task automatic test_keywords();
        send_text("servo90#");
        send_text("lcd12#");
        send_text("ledon#");
        send_text("ledoff#");
        send_text("#");
        send_text("servoo#");
        send_text("serv#");
        send_text("led#");
        send_text("Servo3#");
    endtask

    task automatic test_led_pins();
        send_text("ledon1#");
        send_text("ledon4#");
        send_text(" led on 2 #");
        send_text("3ledon#");
        send_text("ledoff1#");
        send_text("ledon5#");
        send_text("ledoff0#");
        send_text("le1d2on#");
        send_text("ledoff4#");
    endtask

    task automatic test_number_edges();
        send_text("servo65535#");
        send_text("servo65536#");
        send_text("lcd99999#");
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h7B);
        send_text("7#");
    endtask

    task automatic test_limits();
        send_text("abcdefgh#");
        send_text("abcdefghi5#");
        // Exactly the frame limit, spaces not counted: still decoded.
        send_text("led on");
        repeat (MAX_FRAME - 6) send_byte(CH_0);
        send_text(" 3#");
        // One byte past the limit: flagged, LED3 stays on.
        send_text("ledoff");
        repeat (MAX_FRAME - 6) send_byte(CH_0);
        send_text("3#");
        send_text("#");
    endtask

    task automatic test_drain_pause();
        send_text("led");
        pause_sender();
        send_text("on2#");
        repeat (4) begin
            send_random_frame();
            pause_sender();
        end
    endtask

    task automatic test_random_traffic();
        int n;
        n = 0;
        while (bytes_sent < TARGET_RANDOM_BYTES) begin
            // Now and then a stretch without gaps or stalls.
            if (n % 16 == 0) begin
                gaps_on = ($urandom_range(0, 3) != 0);
                stalls_on = ($urandom_range(0, 3) != 0);
            end
            send_random_frame();
            n++;
        end
    endtask

    task automatic test_steady_stream();
        gaps_on = 1'b0;
        stalls_on = 1'b0;
        while (bytes_sent < TARGET_TOTAL_BYTES)
            send_random_frame();
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_rx_valid = 1'b0;
        i_rx_byte = '0;
        led_state = '0;
        clear_frame_state();
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_keywords();
        test_led_pins();
        test_number_edges();
        test_limits();
        test_drain_pause();
        test_random_traffic();
        test_steady_stream();

        pause_sender();
        repeat (10) @(posedge i_clk);

        $display("Sent %0d frames (%0d bytes) covering all commands, LED updates,",
                 frames_sent, bytes_sent);
        $display("number wrap and both overflow limits; %0d results checked, %0d mismatches.",
                 results_seen, mismatches);
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

`default_nettype wire

// File: text_command_frame_decoder.f
+incdir+rtl
rtl/tcfd_pkg.sv
rtl/text_command_frame_decoder.sv
test/tb_top.sv
